/* sv/assert_macros.svh */
// Assertion macros for the checker module of the tone generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PATG_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PATG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/patg_pkg.sv */
// Package of constants, types and tables for the phase accumulator tone generator
`timescale 1ns / 1ps

package patg_pkg;

    // Field and state widths
    localparam int unsigned FREQ_W     = 15;
    localparam int unsigned VOL_W      = 7;
    localparam int unsigned PHASE_W    = 17;
    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned SCALE_W    = 8;
    localparam int unsigned MAG_W      = 7;
    localparam int unsigned DEG_W      = 9;
    localparam int unsigned DIVIDEND_W = 32;
    localparam int unsigned FPROD_W    = 24;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 3;

    // Arithmetic constants
    localparam int unsigned PHASE_DEG   = 360;
    localparam int unsigned PHASE_FRAC  = 8;
    localparam int unsigned PHASE_WRAP  = PHASE_DEG * 256;
    localparam int unsigned QUARTER_DEG = 90;
    localparam int unsigned HALF_DEG    = 180;
    localparam int unsigned THREEQ_DEG  = 270;
    localparam int unsigned FREQ_MIN    = 20;
    localparam int unsigned FREQ_MAX    = 20000;
    localparam int unsigned FULL_SCALE  = 127;
    localparam int unsigned MIDSCALE    = 128;
    localparam int unsigned VOL_DIV     = 100;
    localparam int unsigned TRI_DIV     = 90;

    // Reset values and default sample rate
    localparam int unsigned RESET_FREQ    = 440;
    localparam int unsigned RESET_VOL     = 80;
    localparam int unsigned RESET_SCALE   = (RESET_VOL * FULL_SCALE) / VOL_DIV;
    localparam int unsigned TICK_RATE_DEF = 22050;

    // Serial divide lengths, in quotient bits
    localparam int unsigned STEP_DIV_BITS   = DIVIDEND_W;
    localparam int unsigned SCALE_DIV_BITS  = VOL_W + 7;
    localparam int unsigned SAMPLE_DIV_BITS = MAG_W + SCALE_W;
    localparam int unsigned CNT_W           = $clog2(DIVIDEND_W + 1);

    // Register indexes (byte address bit 2)
    localparam logic REG_TONE_FREQ = 1'b0;
    localparam logic REG_VOLUME    = 1'b1;

    // Jobs of the shared serial divider
    typedef enum logic [1:0] {
        JOB_STEP   = 2'd0,
        JOB_SCALE  = 2'd1,
        JOB_SAMPLE = 2'd2
    } t_div_job;

    // Quarter-wave table: degrees 0..90 to magnitude 0..127
    localparam int unsigned TRI_ENTRIES = QUARTER_DEG + 1;
    typedef logic [MAG_W-1:0] t_tri_tab [TRI_ENTRIES];

    function automatic t_tri_tab tri_table();
        t_tri_tab tab;
        for (int unsigned i = 0; i < TRI_ENTRIES; i++) begin
            tab[i] = MAG_W'((i * FULL_SCALE) / TRI_DIV);
        end
        return tab;
    endfunction

endpackage

/* sv/phase_accumulator_tone_generator.sv */
// Top level of the phase accumulator tone generator with its bit-serial divider
`timescale 1ns / 1ps
// Usage
//   Input stream (i_s_tvalid / o_s_tready / i_s_tdata): one transaction per audio
//   tick; bit 0 of tdata asks for the phase to restart at zero. Output stream
//   (o_m_tvalid / i_m_tready / o_m_tdata / o_m_tuser): one 8-bit unsigned sample
//   per tick, tuser flags a frequency outside 20..20000 Hz (sample is then 128).
//   APB port: register 0 (address 0) tone frequency, register 1 (address 4) volume.
// Sequence
//   A valid-frequency input passes from S_IDLE through S_MUL and S_SDIV to S_DONE,
//   and the next input is taken only once the sequencer is back in S_IDLE: the
//   magnitude times scale is divided by 127 one quotient bit per cycle (15 bits) in
//   the shared restoring divider. With an invalid frequency the input goes from
//   S_IDLE straight to S_DONE, with no division.
//   A frequency write recomputes the phase step (32 quotient bits), a volume write
//   the amplitude scale (14 bits); o_s_tready stays low meanwhile.
// Reset
//   Synchronous, active low: phase 0, 440 Hz, 80 percent, step and scale preset.
// Stalls
//   A finished sample waits in the output register; the next input is still taken,
//   and its result waits until the held sample has been taken.
module phase_accumulator_tone_generator #(
    parameter int unsigned TICK_RATE_HZ = patg_pkg::TICK_RATE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,   // [0] restart_phase
    // Output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [7:0]                          o_m_tdata,   // [7:0] sample
    output logic                                o_m_tuser,   // [0] frequency_invalid
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [patg_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [patg_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [patg_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int unsigned DIV_W      = $clog2(TICK_RATE_HZ + 1);
    localparam int unsigned RESET_STEP =
        (patg_pkg::RESET_FREQ * patg_pkg::PHASE_WRAP) / TICK_RATE_HZ;
    localparam patg_pkg::t_tri_tab TRI_TAB = patg_pkg::tri_table();

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CDIV = 5'b00010,
        S_MUL  = 5'b00100,
        S_SDIV = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // Control registers
    t_state                              r_state, n_state;
    logic                                r_step_dirty, n_step_dirty;
    logic                                r_scale_dirty, n_scale_dirty;
    logic [patg_pkg::FREQ_W-1:0]         r_tone_frequency, n_tone_frequency;
    logic [patg_pkg::VOL_W-1:0]          r_volume_percent, n_volume_percent;
    logic [patg_pkg::PHASE_W-1:0]        r_phase_step, n_phase_step;
    logic [patg_pkg::SCALE_W-1:0]        r_scale, n_scale;
    logic [patg_pkg::PHASE_W-1:0]        r_phase_acc, n_phase_acc;
    logic                                r_out_valid, n_out_valid;

    // Payload registers
    patg_pkg::t_div_job                  r_job, n_job;
    logic [patg_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic [DIV_W-1:0]                    r_rem, n_rem;
    logic [patg_pkg::DIVIDEND_W-1:0]     r_quo, n_quo;
    logic [patg_pkg::MAG_W-1:0]          r_mag, n_mag;
    logic                                r_neg, n_neg;
    logic                                r_inval, n_inval;
    logic [patg_pkg::SAMPLE_W-1:0]       r_out_sample, n_out_sample;
    logic                                r_out_invalid, n_out_invalid;

    logic                                cfg_wr;
    logic                                freq_ok;
    logic                                s_take;
    logic                                out_free;
    logic [patg_pkg::PHASE_W-1:0]        acc0;
    logic [patg_pkg::DEG_W-1:0]          deg;
    logic [patg_pkg::DEG_W-1:0]          quad_x;
    logic                                quad_neg;
    logic [patg_pkg::PHASE_W:0]          acc_sum;
    logic [patg_pkg::PHASE_W:0]          acc_wrap;
    logic [patg_pkg::FPROD_W-1:0]        freq_prod;
    logic [patg_pkg::SCALE_DIV_BITS-1:0] vol_prod;
    logic [patg_pkg::SAMPLE_DIV_BITS-1:0] amp_prod;
    logic [DIV_W-1:0]                    divisor;
    logic [DIV_W:0]                      trial;
    logic [DIV_W:0]                      trial_diff;
    logic                                trial_ge;
    logic [patg_pkg::SAMPLE_W-1:0]       quot;
    logic [patg_pkg::SAMPLE_W:0]         up_sum;
    logic [patg_pkg::SAMPLE_W:0]         dn_sum;
    logic [patg_pkg::SAMPLE_W-1:0]       wave_sample;

    // APB: writes land at once, reads are combinational
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            patg_pkg::REG_TONE_FREQ: prdata = patg_pkg::CFG_DATA_W'(r_tone_frequency);
            patg_pkg::REG_VOLUME:    prdata = patg_pkg::CFG_DATA_W'(r_volume_percent);
            default:                 prdata = '0;
        endcase
    end

    // Stream handshakes
    assign o_s_tready = (r_state == S_IDLE) && !r_step_dirty && !r_scale_dirty;
    assign s_take     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_sample;
    assign o_m_tuser  = r_out_invalid;

    assign freq_ok = (r_tone_frequency >= patg_pkg::FREQ_W'(patg_pkg::FREQ_MIN)) &&
                     (r_tone_frequency <= patg_pkg::FREQ_W'(patg_pkg::FREQ_MAX));

    // Phase in whole degrees, folded into one quarter wave
    assign acc0 = i_s_tdata[0] ? '0 : r_phase_acc;
    assign deg  = acc0[patg_pkg::PHASE_W-1:patg_pkg::PHASE_FRAC];

    always_comb begin
        if (deg <= patg_pkg::DEG_W'(patg_pkg::QUARTER_DEG)) begin
            quad_x   = deg;
            quad_neg = 1'b0;
        end else if (deg <= patg_pkg::DEG_W'(patg_pkg::HALF_DEG)) begin
            quad_x   = patg_pkg::DEG_W'(patg_pkg::HALF_DEG) - deg;
            quad_neg = 1'b0;
        end else if (deg <= patg_pkg::DEG_W'(patg_pkg::THREEQ_DEG)) begin
            quad_x   = deg - patg_pkg::DEG_W'(patg_pkg::HALF_DEG);
            quad_neg = 1'b1;
        end else begin
            quad_x   = patg_pkg::DEG_W'(patg_pkg::PHASE_DEG) - deg;
            quad_neg = 1'b1;
        end
    end

    // Advance the phase and wrap at one full turn
    assign acc_sum  = {1'b0, acc0} + {1'b0, r_phase_step};
    assign acc_wrap = (acc_sum >= (patg_pkg::PHASE_W + 1)'(patg_pkg::PHASE_WRAP)) ?
                      acc_sum - (patg_pkg::PHASE_W + 1)'(patg_pkg::PHASE_WRAP) : acc_sum;

    // Dividends for the three divider jobs
    assign freq_prod = patg_pkg::FPROD_W'(r_tone_frequency) *
                       patg_pkg::FPROD_W'(patg_pkg::PHASE_DEG);
    assign vol_prod  = patg_pkg::SCALE_DIV_BITS'(r_volume_percent) *
                       patg_pkg::SCALE_DIV_BITS'(patg_pkg::FULL_SCALE);
    assign amp_prod  = patg_pkg::SAMPLE_DIV_BITS'(r_mag) *
                       patg_pkg::SAMPLE_DIV_BITS'(r_scale);

    // Restoring divider: one quotient bit per cycle
    always_comb begin
        case (r_job)
            patg_pkg::JOB_STEP:  divisor = DIV_W'(TICK_RATE_HZ);
            patg_pkg::JOB_SCALE: divisor = DIV_W'(patg_pkg::VOL_DIV);
            default:             divisor = DIV_W'(patg_pkg::FULL_SCALE);
        endcase
    end

    assign trial      = {r_rem, r_quo[patg_pkg::DIVIDEND_W-1]};
    assign trial_ge   = trial >= {1'b0, divisor};
    assign trial_diff = trial - {1'b0, divisor};

    // Offset the scaled wave around midscale and clamp to 0..255
    assign quot   = r_quo[patg_pkg::SAMPLE_W-1:0];
    assign up_sum = (patg_pkg::SAMPLE_W + 1)'(patg_pkg::MIDSCALE) + {1'b0, quot};
    assign dn_sum = (patg_pkg::SAMPLE_W + 1)'(patg_pkg::MIDSCALE) - {1'b0, quot};

    always_comb begin
        if (r_neg) begin
            wave_sample = (quot > patg_pkg::SAMPLE_W'(patg_pkg::MIDSCALE)) ?
                          '0 : dn_sum[patg_pkg::SAMPLE_W-1:0];
        end else begin
            wave_sample = up_sum[patg_pkg::SAMPLE_W] ?
                          '1 : up_sum[patg_pkg::SAMPLE_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state          = r_state;
        n_step_dirty     = r_step_dirty;
        n_scale_dirty    = r_scale_dirty;
        n_tone_frequency = r_tone_frequency;
        n_volume_percent = r_volume_percent;
        n_phase_step     = r_phase_step;
        n_scale          = r_scale;
        n_phase_acc      = r_phase_acc;
        n_out_valid      = r_out_valid;
        n_job            = r_job;
        n_cnt            = r_cnt;
        n_rem            = r_rem;
        n_quo            = r_quo;
        n_mag            = r_mag;
        n_neg            = r_neg;
        n_inval          = r_inval;
        n_out_sample     = r_out_sample;
        n_out_invalid    = r_out_invalid;

        // Drop the output transaction once taken
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (r_step_dirty) begin
                    n_step_dirty = 1'b0;
                    n_job        = patg_pkg::JOB_STEP;
                    n_quo        = {freq_prod, patg_pkg::PHASE_FRAC'(0)};
                    n_rem        = '0;
                    n_cnt        = patg_pkg::CNT_W'(patg_pkg::STEP_DIV_BITS);
                    n_state      = S_CDIV;
                end else if (r_scale_dirty) begin
                    n_scale_dirty = 1'b0;
                    n_job         = patg_pkg::JOB_SCALE;
                    n_quo         = {vol_prod,
                                     (patg_pkg::DIVIDEND_W - patg_pkg::SCALE_DIV_BITS)'(0)};
                    n_rem         = '0;
                    n_cnt         = patg_pkg::CNT_W'(patg_pkg::SCALE_DIV_BITS);
                    n_state       = S_CDIV;
                end else if (s_take) begin
                    n_inval = !freq_ok;
                    if (freq_ok) begin
                        n_mag       = TRI_TAB[quad_x[patg_pkg::MAG_W-1:0]];
                        n_neg       = quad_neg;
                        n_phase_acc = acc_wrap[patg_pkg::PHASE_W-1:0];
                        n_state     = S_MUL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CDIV: begin
                if (r_cnt != '0) begin
                    n_rem = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
                    n_quo = {r_quo[patg_pkg::DIVIDEND_W-2:0], trial_ge};
                    n_cnt = r_cnt - patg_pkg::CNT_W'(1);
                end else begin
                    // Commit the finished quotient
                    if (r_job == patg_pkg::JOB_STEP) begin
                        n_phase_step = r_quo[patg_pkg::PHASE_W-1:0];
                    end else begin
                        n_scale = r_quo[patg_pkg::SCALE_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_job   = patg_pkg::JOB_SAMPLE;
                n_quo   = {amp_prod,
                           (patg_pkg::DIVIDEND_W - patg_pkg::SAMPLE_DIV_BITS)'(0)};
                n_rem   = '0;
                n_cnt   = patg_pkg::CNT_W'(patg_pkg::SAMPLE_DIV_BITS);
                n_state = S_SDIV;
            end
            S_SDIV: begin
                if (r_cnt != '0) begin
                    n_rem = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
                    n_quo = {r_quo[patg_pkg::DIVIDEND_W-2:0], trial_ge};
                    n_cnt = r_cnt - patg_pkg::CNT_W'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_invalid = r_inval;
                    n_out_sample  = r_inval ? patg_pkg::SAMPLE_W'(patg_pkg::MIDSCALE) :
                                              wave_sample;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Register writes; a write sets its dirty flag even when a job start clears it in the same cycle
        if (cfg_wr) begin
            case (paddr[2])
                patg_pkg::REG_TONE_FREQ: begin
                    n_tone_frequency = pwdata[patg_pkg::FREQ_W-1:0];
                    n_step_dirty     = 1'b1;
                end
                patg_pkg::REG_VOLUME: begin
                    n_volume_percent = pwdata[patg_pkg::VOL_W-1:0];
                    n_scale_dirty    = 1'b1;
                end
                default: begin
                    n_step_dirty = n_step_dirty;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_step_dirty     <= 1'b0;
            r_scale_dirty    <= 1'b0;
            r_tone_frequency <= patg_pkg::FREQ_W'(patg_pkg::RESET_FREQ);
            r_volume_percent <= patg_pkg::VOL_W'(patg_pkg::RESET_VOL);
            r_phase_step     <= patg_pkg::PHASE_W'(RESET_STEP);
            r_scale          <= patg_pkg::SCALE_W'(patg_pkg::RESET_SCALE);
            r_phase_acc      <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_step_dirty     <= n_step_dirty;
            r_scale_dirty    <= n_scale_dirty;
            r_tone_frequency <= n_tone_frequency;
            r_volume_percent <= n_volume_percent;
            r_phase_step     <= n_phase_step;
            r_scale          <= n_scale;
            r_phase_acc      <= n_phase_acc;
            r_out_valid      <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_job         <= n_job;
        r_cnt         <= n_cnt;
        r_rem         <= n_rem;
        r_quo         <= n_quo;
        r_mag         <= n_mag;
        r_neg         <= n_neg;
        r_inval       <= n_inval;
        r_out_sample  <= n_out_sample;
        r_out_invalid <= n_out_invalid;
    end

endmodule

/* sv/patg_checker.sv */
// Port checker for the tone generator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module patg_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [7:0]                       o_m_tdata,
    input logic                             o_m_tuser,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic                             pready
);

    // A flagged frequency always comes out as silence
    `PATG_ASSERT_SAME(a_invalid_silence, o_m_tvalid && o_m_tuser, o_m_tdata == 8'(patg_pkg::MIDSCALE), "flagged sample is not midscale")

    // A register write holds off input while step or scale is recomputed
    `PATG_ASSERT_NEXT(a_cfg_blocks_input, psel && penable && pwrite && pready, !o_s_tready, "input taken during recompute")

    // One item at a time: an accepted transaction closes the input
    `PATG_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready, "second item taken while busy")

    // A stalled output transaction holds its payload
    `PATG_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled output changed")

endmodule

bind phase_accumulator_tone_generator patg_checker u_patg_checker (.*);
